FILE: src/psc_pkg.sv
// shared constants and types of the palindromic subsequence counter
package psc_pkg;

  localparam int unsigned MAX_LEN = 32;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned CH_W    = 8;
  localparam int unsigned CNT_W   = 32;

  // update wave handed from one cell to the next lower one
  typedef struct packed {
    logic             vld;
    logic [CH_W-1:0]  ch;     // character that started the wave
    logic [CNT_W-1:0] below;  // new entry of the cell above
    logic [CNT_W-1:0] prev;   // old entry of the cell above
  } wave_t;

endpackage

FILE: src/psc_if.sv
// handshake channels of the palindromic subsequence counter
interface psc_in_if;
  logic                      valid;
  logic                      ready;
  logic [psc_pkg::CH_W-1:0]  ch;
  logic                      last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface psc_out_if;
  logic                      valid;
  logic                      ready;
  logic [psc_pkg::CNT_W-1:0] count;
  logic                      too_long;

  modport source (output valid, count, too_long, input ready);
  modport sink   (input valid, count, too_long, output ready);
endinterface

FILE: src/psc_cell.sv
// one cell of the column chain: one stored character and one table entry
module psc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [psc_pkg::CH_W-1:0] ch_i,
  input  psc_pkg::wave_t           wave_i,
  output psc_pkg::wave_t           wave_o
);
  import psc_pkg::*;

  logic [CH_W-1:0]  char_q;
  logic [CNT_W-1:0] col_q;
  logic [CNT_W-1:0] sum;
  logic [CNT_W-1:0] col_d;
  logic             vld_q;
  logic [CH_W-1:0]  wch_q;
  logic [CNT_W-1:0] wbelow_q;
  logic [CNT_W-1:0] wprev_q;

  // equal ends add one, otherwise the inner range is counted twice
  assign sum   = wave_i.below + col_q;
  assign col_d = (wave_i.ch == char_q) ? sum + CNT_W'(1) : sum - wave_i.prev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i | wave_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      char_q   <= ch_i;
      col_q    <= CNT_W'(1);
      wch_q    <= ch_i;
      wbelow_q <= CNT_W'(1);
      wprev_q  <= '0;
    end else if (wave_i.vld) begin
      col_q    <= col_d;
      wch_q    <= wave_i.ch;
      wbelow_q <= col_d;
      wprev_q  <= col_q;
    end
  end

  assign wave_o = '{vld: vld_q, ch: wch_q, below: wbelow_q, prev: wprev_q};

endmodule

FILE: src/palindromic_subsequence_counter_top.sv
// top level: counts palindromic subsequences of a byte string with a chain of cells
// order: a character stored at position j sends a wave down j+1 cells; the count of a
//   final character goes from cell 0 to the result and then the output register, a too long
//   string goes straight to them; the next beat waits until the wave has left cell 0, which
//   walks one cell per cycle; a held result stalls input
// reset: length, overflow flag and all handshake state clear; stores need no clearing
module palindromic_subsequence_counter_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  psc_in_if.sink    in_i,
  psc_out_if.source out_o
);
  import psc_pkg::*;

  // chain[k] is the wave leaving cell k; the top end is idle
  wave_t chain [MAX_LEN+1];
  logic [MAX_LEN-1:0] start;

  logic [LEN_W-1:0] len_q;
  logic             ovf_q;
  logic             run_q;       // wave in flight
  logic             last_q;      // character in flight ends the string
  logic             res_pend_q;  // result waiting for the output register
  logic [CNT_W-1:0] res_cnt_q;
  logic             res_tl_q;
  logic             out_vld_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_tl_q;

  logic accept;
  logic full;
  logic done;
  logic out_free;

  assign full     = (len_q == LEN_W'(MAX_LEN));
  assign in_i.ready = !run_q && !res_pend_q;
  assign accept   = in_i.valid && in_i.ready;
  // the wave leaving cell 0 carries the entry for the whole string
  assign done     = chain[0].vld;
  assign out_free = !out_vld_q || out_o.ready;

  assign chain[MAX_LEN] = '0;

  // the new character goes to the cell at the current length
  always_comb begin
    for (int k = 0; k < MAX_LEN; k++) begin
      start[k] = accept && !full && !ovf_q && (len_q == LEN_W'(k));
    end
  end

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    psc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start[k]),
      .ch_i    (in_i.ch),
      .wave_i  (chain[k+1]),
      .wave_o  (chain[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      ovf_q      <= 1'b0;
      run_q      <= 1'b0;
      last_q     <= 1'b0;
      res_pend_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (accept) begin
        if (full || ovf_q) begin
          // character dropped, the string is too long
          if (in_i.last) begin
            res_pend_q <= 1'b1;
            len_q      <= '0;
            ovf_q      <= 1'b0;
          end else begin
            ovf_q <= 1'b1;
          end
        end else begin
          run_q  <= 1'b1;
          last_q <= in_i.last;
          len_q  <= in_i.last ? '0 : len_q + LEN_W'(1);
        end
      end
      if (done) begin
        run_q <= 1'b0;
        if (last_q) begin
          res_pend_q <= 1'b1;
        end
      end
      // hand the pending result to the output register
      if (res_pend_q && out_free) begin
        res_pend_q <= 1'b0;
        out_vld_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (full || ovf_q)) begin
      res_cnt_q <= '0;
      res_tl_q  <= 1'b1;
    end else if (done) begin
      res_cnt_q <= chain[0].below;
      res_tl_q  <= 1'b0;
    end
    if (res_pend_q && out_free) begin
      out_cnt_q <= res_cnt_q;
      out_tl_q  <= res_tl_q;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.count    = out_cnt_q;
  assign out_o.too_long = out_tl_q;

  // the chain only drains while a wave was launched
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> run_q)
    else $error("wave left the chain with no character in flight");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_LEN))
    else $error("stored length beyond capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flag set with room left");

  a_start_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(start))
    else $error("more than one cell started");

endmodule

FILE: tb/psc_checker.sv
// checker for the palindromic subsequence counter: predicts counts and compares result beats
module psc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  psc_in_if           in_i,
  psc_out_if          out_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import psc_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             too_long;
  } tally_t;

  logic [CH_W-1:0]  seen_chars  [MAX_LEN];
  logic [CNT_W-1:0] span_counts [MAX_LEN];
  int unsigned      str_len;
  bit               over_len;
  tally_t           tally_q [$];
  int unsigned      fail_total;
  int unsigned      checked_total;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_total++;
  endtask

  // folds one character into the interval column, queues a count on the final one
  task automatic absorb_char(input logic [CH_W-1:0] c, input logic fin);
    logic [CNT_W-1:0] inner;
    logic [CNT_W-1:0] below;
    logic [CNT_W-1:0] old;
    logic [CNT_W-1:0] v;
    int unsigned      j;
    tally_t           t;
    j = str_len;
    if (j >= MAX_LEN) begin
      over_len = 1'b1;
    end else begin
      seen_chars[j]  = c;
      span_counts[j] = 1;
      below          = 1;
      inner          = '0;
      for (int i = j; i > 0; i--) begin
        old = span_counts[i-1];
        v   = below + old;
        if (seen_chars[i-1] == c) begin
          v = v + 1;
        end else begin
          v = v - inner;
        end
        span_counts[i-1] = v;
        inner            = old;
        below            = v;
      end
      str_len = j + 1;
    end
    if (fin) begin
      t.too_long = over_len;
      t.count    = over_len ? '0 : span_counts[0];
      tally_q.push_back(t);
      str_len  = 0;
      over_len = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t exp_t;
    if (!rst_ni) begin
      str_len       = 0;
      over_len      = 1'b0;
      fail_total    = 0;
      checked_total = 0;
      tally_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (tally_q.size() == 0) begin
          report_mismatch($sformatf("count %h too_long %b with none expected",
                                    out_i.count, out_i.too_long));
        end else begin
          exp_t = tally_q.pop_front();
          checked_total++;
          if (out_i.count !== exp_t.count)
            report_mismatch($sformatf("count %h, expected %h", out_i.count, exp_t.count));
          if (out_i.too_long !== exp_t.too_long)
            report_mismatch($sformatf("too_long %b, expected %b",
                                      out_i.too_long, exp_t.too_long));
        end
      end
      if (in_i.valid && in_i.ready)
        absorb_char(in_i.ch, in_i.last);
    end
    fail_cnt_o <= fail_total;
    pending_o  <= tally_q.size();
    checked_o  <= checked_total;
  end

endmodule

FILE: tb/tb.sv
// testbench top: drives strings into the palindromic subsequence counter and gives the verdict
module tb;
  import psc_pkg::*;

  // generous bound, the slowest correct run stays far below it
  localparam int unsigned LIMIT       = 1000000;
  // drain time after the last count, covers a full wave down the cell chain
  localparam int unsigned DRAIN       = MAX_LEN + 16;
  localparam int unsigned PHASE_CHARS = 470;

  logic clk;
  logic rst_n;

  psc_in_if  in_if();
  psc_out_if out_if();

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;

  // idle mix of the current phase, in percent
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  int unsigned cycle_cnt = 0;
  int unsigned total_chars;
  int unsigned total_strings;
  int unsigned long_strings;
  int unsigned full_strings;

  palindromic_subsequence_counter_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  psc_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_i      (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver side: random stalls on the result channel, one draw per cycle
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog, ends a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles, %0d counts still owed", cycle_cnt, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one character beat: optional idle cycles first, then hold valid until accepted
  // valid stays high into the next beat; between beats it is only lowered by an idle cycle
  task automatic send_char(input logic [CH_W-1:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.last  <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    total_chars++;
  endtask

  // whole string of random content; alphabet 0 means any byte, else that many letters
  // small alphabets give many equal pairs, so both branches of the update get used
  task automatic send_string(input int unsigned len, input int unsigned alph);
    logic [CH_W-1:0] c;
    for (int k = 0; k < len; k++) begin
      if (alph == 0) begin
        c = CH_W'($urandom_range(255));
      end else begin
        c = CH_W'(8'h61 + $urandom_range(alph - 1));
      end
      send_char(c, k == len - 1);
    end
    total_strings++;
    if (len > MAX_LEN) long_strings++;
    if (len == MAX_LEN) full_strings++;
  endtask

  initial begin
    int unsigned phase_chars;
    int unsigned n;
    int unsigned len;
    int unsigned alph;
    int unsigned r;

    // every input known from time zero
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.ch      = '0;
    in_if.last    = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    total_chars   = 0;
    total_strings = 0;
    long_strings  = 0;
    full_strings  = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings: byte extremes, single characters, equal and unequal pairs,
    // odd palindromes
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b1);
    send_char(8'h55, 1'b0);
    send_char(8'h55, 1'b1);
    send_char(8'haa, 1'b0);
    send_char(8'h55, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h61, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h63, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h61, 1'b1);
    total_strings += 7;

    // random part in four idle mixes: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct <= 0;
          stall_pct     <= 0;
        end
        1: begin
          send_idle_pct <= 61;
          stall_pct     <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          stall_pct     <= 61;
        end
        default: begin
          send_idle_pct <= 36;
          stall_pct     <= 36;
        end
      endcase
      phase_chars = 0;
      n           = 0;
      while (phase_chars < PHASE_CHARS) begin
        r = $urandom_range(99);
        if (n == 0) begin
          // full length of one letter, largest count the block can give
          len  = MAX_LEN;
          alph = 1;
        end else if (n == 1) begin
          // just past the limit, the drop path
          len  = MAX_LEN + 1 + $urandom_range(3);
          alph = $urandom_range(4);
        end else begin
          alph = ($urandom_range(99) < 20) ? 0 : $urandom_range(1, 4);
          if (r < 6) begin
            len = MAX_LEN;
          end else if (r < 12) begin
            len = MAX_LEN + $urandom_range(1, 8);
          end else if (r < 20) begin
            len = 1;
          end else if (r < 70) begin
            len = $urandom_range(2, 8);
          end else begin
            len = $urandom_range(9, MAX_LEN - 1);
          end
        end
        send_string(len, alph);
        phase_chars += len;
        n++;
      end
    end
    in_if.valid <= 1'b0;

    // wait for every owed count, then let the chain settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("drove %0d characters in %0d strings, %0d at full length, %0d over length",
             total_chars, total_strings, full_strings, long_strings);
    $display("checked %0d counts under four idle mixes, %0d mismatches", checked, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
